[rtl/ata_pkg.sv]
// ----------------------------------------------------------------------------
// ata_pkg
// Shared types and constants for the threshold alarm unit pool.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int unsigned UNITS     = 6;
  localparam int unsigned CODE_W    = 12;
  localparam int unsigned INPUT_W   = 5;
  localparam int unsigned TRIP_W    = 32;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned AIN_W     = 6;
  localparam int unsigned BOUND_W   = 16;
  localparam int unsigned SCAN_W    = 32;
  localparam logic [BOUND_W-1:0] MAX_CODE  = 16'd4095;
  localparam logic [AIN_W-1:0]   MAX_INPUT = 6'd31;

  typedef enum logic [2:0] {
    CMD_SAMPLE = 3'd0,
    CMD_CONFIG = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_REVAL  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_BELOW   = 3'd1,
    MODE_ABOVE   = 3'd2,
    MODE_INSIDE  = 3'd3,
    MODE_OUTSIDE = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MODE   = 3'd1,
    ST_BAD_BOUNDS = 3'd2,
    ST_BAD_INPUT  = 3'd3,
    ST_NO_UNIT    = 3'd4
  } status_e;

  // command broadcast to every cell
  typedef struct packed {
    logic                valid;
    logic [2:0]          cmd;
    logic [CHAN_W-1:0]   channel;
    logic [AIN_W-1:0]    ain;
    logic                dedicated;
    logic [2:0]          mode;
    logic [CODE_W-1:0]   low;
    logic [CODE_W-1:0]   high;
    logic [CODE_W-1:0]   smp;
    logic                all;
    logic                cfg_ok;
    logic                hit_any;
    logic [SCAN_W-1:0]   scan_mask;
  } op_t;

  // priority chain handed from cell to cell
  typedef struct packed {
    logic                hit;
    logic                free;
    logic                any_lat;
    logic [2:0]          mode;
    logic [CODE_W-1:0]   low;
    logic [CODE_W-1:0]   high;
    logic [TRIP_W-1:0]   trips;
    logic                lat;
  } chain_t;

endpackage

[rtl/adc_threshold_alarm_units_top.sv]
// ----------------------------------------------------------------------------
// adc_threshold_alarm_units_top
// Timing: the command register holds an accepted command, the result register
//   its result strobe; the receiver cannot stall and done_o lasts one cycle.
// Throughput: one command per cycle; busy_o stays low. The six unit cells
//   and their lookup chain evaluate a command combinationally.
// Reset: asynchronous, active low; all units free, scan_mask zero.
// ----------------------------------------------------------------------------
// Threshold alarm pool
// Command register, a row of alarm unit cells, and a result register.
// ----------------------------------------------------------------------------
module adc_threshold_alarm_units_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  cmd_i,
  input  logic [ata_pkg::CHAN_W-1:0]  channel_i,
  input  logic [ata_pkg::AIN_W-1:0]   analog_input_i,
  input  logic                        dedicated_i,
  input  logic [2:0]                  alarm_mode_i,
  input  logic [ata_pkg::BOUND_W-1:0] low_bound_i,
  input  logic [ata_pkg::BOUND_W-1:0] high_bound_i,
  input  logic [ata_pkg::CODE_W-1:0]  sample_i,
  input  logic                        all_channels_i,
  input  logic                        scan_mask_we_i,
  input  logic [ata_pkg::SCAN_W-1:0]  scan_mask_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic                        found_o,
  output logic [2:0]                  mode_out_o,
  output logic [ata_pkg::CODE_W-1:0]  low_out_o,
  output logic [ata_pkg::CODE_W-1:0]  high_out_o,
  output logic [ata_pkg::TRIP_W-1:0]  trip_count_o,
  output logic                        latched_out_o,
  output logic                        any_latched_o,
  output logic [ata_pkg::UNITS-1:0]   unit_mask_o
);

  logic                         req_vld_q;
  logic [2:0]                   cmd_q;
  logic [ata_pkg::CHAN_W-1:0]   chan_q;
  logic [ata_pkg::AIN_W-1:0]    ain_q;
  logic                         ded_q;
  logic [2:0]                   mode_q;
  logic [ata_pkg::BOUND_W-1:0]  low_q;
  logic [ata_pkg::BOUND_W-1:0]  high_q;
  logic [ata_pkg::CODE_W-1:0]   smp_q;
  logic                         all_q;
  logic [ata_pkg::SCAN_W-1:0]   scan_mask_q;

  ata_pkg::op_t                 op;
  ata_pkg::chain_t              chain [ata_pkg::UNITS+1];
  logic [ata_pkg::UNITS-1:0]    cell_mask;
  ata_pkg::status_e             pre_status, status_d;
  logic                         is_query;

  logic                         done_q;
  logic [2:0]                   status_q;
  logic                         found_q;
  logic [2:0]                   mode_out_q;
  logic [ata_pkg::CODE_W-1:0]   low_out_q;
  logic [ata_pkg::CODE_W-1:0]   high_out_q;
  logic [ata_pkg::TRIP_W-1:0]   trips_out_q;
  logic                         lat_out_q;
  logic                         any_lat_q;
  logic [ata_pkg::UNITS-1:0]    mask_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q   <= 1'b0;
      scan_mask_q <= '0;
    end else begin
      req_vld_q <= start_i && !busy_o;
      if (scan_mask_we_i) begin
        scan_mask_q <= scan_mask_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      cmd_q  <= cmd_i;
      chan_q <= channel_i;
      ain_q  <= analog_input_i;
      ded_q  <= dedicated_i;
      mode_q <= alarm_mode_i;
      low_q  <= low_bound_i;
      high_q <= high_bound_i;
      smp_q  <= sample_i;
      all_q  <= all_channels_i;
    end
  end

  // configure checks in priority order
  always_comb begin
    if (mode_q > ata_pkg::MODE_OUTSIDE) begin
      pre_status = ata_pkg::ST_BAD_MODE;
    end else if (mode_q != ata_pkg::MODE_OFF &&
                 (low_q > ata_pkg::MAX_CODE || high_q > ata_pkg::MAX_CODE ||
                  low_q > high_q)) begin
      pre_status = ata_pkg::ST_BAD_BOUNDS;
    end else if (mode_q != ata_pkg::MODE_OFF && ain_q > ata_pkg::MAX_INPUT) begin
      pre_status = ata_pkg::ST_BAD_INPUT;
    end else begin
      pre_status = ata_pkg::ST_OK;
    end
  end

  always_comb begin
    op.valid     = req_vld_q;
    op.cmd       = cmd_q;
    op.channel   = chan_q;
    op.ain       = ain_q;
    op.dedicated = ded_q;
    op.mode      = mode_q;
    op.low       = low_q[ata_pkg::CODE_W-1:0];
    op.high      = high_q[ata_pkg::CODE_W-1:0];
    op.smp       = smp_q;
    op.all       = all_q;
    op.cfg_ok    = (pre_status == ata_pkg::ST_OK);
    op.hit_any   = chain[ata_pkg::UNITS].hit;
    op.scan_mask = scan_mask_q;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < ata_pkg::UNITS; g++) begin : g_cell
    ata_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .mask_o  (cell_mask[g])
    );
  end

  always_comb begin
    status_d = ata_pkg::ST_OK;
    if (cmd_q == ata_pkg::CMD_CONFIG) begin
      if (pre_status != ata_pkg::ST_OK) begin
        status_d = pre_status;
      end else if (mode_q != ata_pkg::MODE_OFF && !chain[ata_pkg::UNITS].hit &&
                   !chain[ata_pkg::UNITS].free) begin
        status_d = ata_pkg::ST_NO_UNIT;
      end
    end
  end

  assign is_query = (cmd_q == ata_pkg::CMD_QUERY) && chain[ata_pkg::UNITS].hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      status_q    <= status_d;
      found_q     <= is_query;
      mode_out_q  <= is_query ? chain[ata_pkg::UNITS].mode  : '0;
      low_out_q   <= is_query ? chain[ata_pkg::UNITS].low   : '0;
      high_out_q  <= is_query ? chain[ata_pkg::UNITS].high  : '0;
      trips_out_q <= is_query ? chain[ata_pkg::UNITS].trips : '0;
      lat_out_q   <= is_query && chain[ata_pkg::UNITS].lat;
      any_lat_q   <= chain[ata_pkg::UNITS].any_lat;
      mask_q      <= cell_mask;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign mode_out_o    = mode_out_q;
  assign low_out_o     = low_out_q;
  assign high_out_o    = high_out_q;
  assign trip_count_o  = trips_out_q;
  assign latched_out_o = lat_out_q;
  assign any_latched_o = any_lat_q;
  assign unit_mask_o   = mask_q;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("result strobe without an accepted command");

  a_mask_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && unit_mask_o != '0) |->
      ($past(cmd_i, 2) == ata_pkg::CMD_SAMPLE || $past(cmd_i, 2) == ata_pkg::CMD_REVAL))
    else $error("unit mask set for a command that trips or releases nothing");

  a_status_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ata_pkg::ST_OK) |-> ($past(cmd_i, 2) == ata_pkg::CMD_CONFIG))
    else $error("error status on a non-configure command");

  a_found_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (mode_out_o != ata_pkg::MODE_OFF))
    else $error("query found a unit with mode off");

endmodule

[rtl/ata_cell.sv]
// ----------------------------------------------------------------------------
// ata_cell
// One alarm unit: holds its settings, trip counter and latch, and joins the
// channel lookup / free-unit priority chain.
// ----------------------------------------------------------------------------
module ata_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ata_pkg::op_t    op_i,
  input  ata_pkg::chain_t chain_i,
  output ata_pkg::chain_t chain_o,
  output logic            mask_o
);

  logic                          in_use_q, in_use_d;
  logic [ata_pkg::CHAN_W-1:0]    chan_q, chan_d;
  logic [ata_pkg::INPUT_W-1:0]   input_q, input_d;
  logic                          ded_q, ded_d;
  ata_pkg::mode_e                mode_q, mode_d;
  logic [ata_pkg::CODE_W-1:0]    low_q, low_d;
  logic [ata_pkg::CODE_W-1:0]    high_q, high_d;
  logic [ata_pkg::TRIP_W-1:0]    trips_q, trips_d;
  logic                          lat_q, lat_d;

  logic hit_here, first_hit, first_free;
  logic below, above, in_window;
  logic smp_hit, rel_hit;

  assign hit_here   = in_use_q && (chan_q == op_i.channel);
  assign first_hit  = hit_here && !chain_i.hit;
  assign first_free = !in_use_q && !chain_i.free;

  assign below = op_i.smp < low_q;
  assign above = op_i.smp >= high_q;

  always_comb begin
    case (mode_q)
      ata_pkg::MODE_BELOW:   in_window = below;
      ata_pkg::MODE_ABOVE:   in_window = above;
      ata_pkg::MODE_INSIDE:  in_window = !below && !above;
      ata_pkg::MODE_OUTSIDE: in_window = below || above;
      default:               in_window = 1'b0;
    endcase
  end

  assign smp_hit = in_use_q && ({1'b0, input_q} == op_i.ain) && in_window;
  assign rel_hit = in_use_q && !ded_q && !op_i.scan_mask[input_q];

  always_comb begin
    in_use_d = in_use_q;
    chan_d   = chan_q;
    input_d  = input_q;
    ded_d    = ded_q;
    mode_d   = mode_q;
    low_d    = low_q;
    high_d   = high_q;
    trips_d  = trips_q;
    lat_d    = lat_q;
    mask_o   = 1'b0;
    if (op_i.valid) begin
      case (op_i.cmd)
        ata_pkg::CMD_SAMPLE: begin
          if (smp_hit) begin
            trips_d = trips_q + {{(ata_pkg::TRIP_W-1){1'b0}}, 1'b1};
            lat_d   = 1'b1;
            mask_o  = 1'b1;
          end
        end
        ata_pkg::CMD_CONFIG: begin
          if (op_i.cfg_ok) begin
            if (op_i.mode == ata_pkg::MODE_OFF) begin
              if (first_hit) begin
                in_use_d = 1'b0;
                mode_d   = ata_pkg::MODE_OFF;
                trips_d  = '0;
                lat_d    = 1'b0;
              end
            end else if (first_hit || (!op_i.hit_any && first_free)) begin
              in_use_d = 1'b1;
              chan_d   = op_i.channel;
              input_d  = op_i.ain[ata_pkg::INPUT_W-1:0];
              ded_d    = op_i.dedicated;
              mode_d   = ata_pkg::mode_e'(op_i.mode);
              low_d    = op_i.low;
              high_d   = op_i.high;
              trips_d  = '0;
              lat_d    = 1'b0;
            end
          end
        end
        ata_pkg::CMD_CLEAR: begin
          if (in_use_q && (op_i.all || chan_q == op_i.channel)) begin
            trips_d = '0;
            lat_d   = 1'b0;
          end
        end
        ata_pkg::CMD_REVAL: begin
          if (rel_hit) begin
            in_use_d = 1'b0;
            mode_d   = ata_pkg::MODE_OFF;
            trips_d  = '0;
            lat_d    = 1'b0;
            mask_o   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    chain_o.hit     = chain_i.hit || hit_here;
    chain_o.free    = chain_i.free || !in_use_q;
    chain_o.any_lat = chain_i.any_lat || (in_use_d && lat_d);
    if (first_hit) begin
      chain_o.mode  = mode_q;
      chain_o.low   = low_q;
      chain_o.high  = high_q;
      chain_o.trips = trips_q;
      chain_o.lat   = lat_q;
    end else begin
      chain_o.mode  = chain_i.mode;
      chain_o.low   = chain_i.low;
      chain_o.high  = chain_i.high;
      chain_o.trips = chain_i.trips;
      chain_o.lat   = chain_i.lat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 1'b0;
      chan_q   <= '0;
      input_q  <= '0;
      ded_q    <= 1'b0;
      mode_q   <= ata_pkg::MODE_OFF;
      low_q    <= '0;
      high_q   <= '0;
      trips_q  <= '0;
      lat_q    <= 1'b0;
    end else begin
      in_use_q <= in_use_d;
      chan_q   <= chan_d;
      input_q  <= input_d;
      ded_q    <= ded_d;
      mode_q   <= mode_d;
      low_q    <= low_d;
      high_q   <= high_d;
      trips_q  <= trips_d;
      lat_q    <= lat_d;
    end
  end

endmodule
